[rtl/core/speck_pkg.sv]
// Shared types, codes and round functions for the Speck 128/128 cipher.
// No dependencies; used by speck128_block_cipher.
`default_nettype none

package speck_pkg;

    localparam int WORD_W = 64;
    localparam int ROT_X  = 8;
    localparam int ROT_Y  = 3;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t x;
        word_t y;
    } blk_t;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    function automatic word_t ror_x(input word_t v);
        return {v[ROT_X-1:0], v[WORD_W-1:ROT_X]};
    endfunction

    function automatic word_t rol_x(input word_t v);
        return {v[WORD_W-ROT_X-1:0], v[WORD_W-1:WORD_W-ROT_X]};
    endfunction

    function automatic word_t ror_y(input word_t v);
        return {v[ROT_Y-1:0], v[WORD_W-1:ROT_Y]};
    endfunction

    function automatic word_t rol_y(input word_t v);
        return {v[WORD_W-ROT_Y-1:0], v[WORD_W-1:WORD_W-ROT_Y]};
    endfunction

    // x = (ror8(x) + y) ^ k ; y = rol3(y) ^ x
    function automatic blk_t enc_round(input blk_t b, input word_t k);
        blk_t r;
        r.x = (ror_x(b.x) + b.y) ^ k;
        r.y = rol_y(b.y) ^ r.x;
        return r;
    endfunction

    // y = ror3(y ^ x) ; x = rol8((x ^ k) - y)
    function automatic blk_t dec_round(input blk_t b, input word_t k);
        blk_t r;
        r.y = ror_y(b.y ^ b.x);
        r.x = rol_x((b.x ^ k) - r.y);
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/speck128_block_cipher.sv]
// Speck 128/128 block cipher: unrolled round pipeline plus key expansion.
// Depends on speck_pkg (types, codes, round functions).
// One word per cycle while the output is not stalled and no key expansion runs.
// After reset and after each key write, s_tready stays low while the round keys
// are expanded into registers.
// Reset clears the key registers to zero and all pipeline valid bits.
`default_nettype none

module speck128_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [2*speck_pkg::WORD_W-1:0] s_tdata,   // block_low, block_high
    input  wire                           s_tuser,   // cmd
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [2*speck_pkg::WORD_W-1:0] m_tdata,  // result_low, result_high
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire                           cfg_index,
    input  wire [speck_pkg::WORD_W-1:0]   cfg_data
);
    import speck_pkg::*;

    localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    // key registers and schedule
    word_t             key_low_reg, key_high_reg;
    word_t             ks_k_reg, ks_k_next;
    word_t             ks_l_reg, ks_l_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    word_t             rk_reg [ROUNDS];

    logic cfg_wr;
    logic cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH);

    always_comb
    begin
        ks_k_next = ks_k_reg;
        ks_l_next = ks_l_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cfg_hit)
        begin
            ks_k_next = (cfg_index == REG_KEY_LOW)  ? cfg_data : key_low_reg;
            ks_l_next = (cfg_index == REG_KEY_HIGH) ? cfg_data : key_high_reg;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            ks_l_next = (ror_x(ks_l_reg) + ks_k_reg) ^ WORD_W'(cnt_reg);
            ks_k_next = rol_y(ks_k_reg) ^ ks_l_next;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROUNDS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            ks_k_reg     <= '0;
            ks_l_reg     <= '0;
            cnt_reg      <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_wr && cfg_index == REG_KEY_LOW)
            begin
                key_low_reg <= cfg_data;
            end
            if (cfg_wr && cfg_index == REG_KEY_HIGH)
            begin
                key_high_reg <= cfg_data;
            end
            ks_k_reg <= ks_k_next;
            ks_l_reg <= ks_l_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_hit)
        begin
            rk_reg[cnt_reg] <= ks_k_reg;
        end
    end

    // round pipeline, one round per stage, global advance
    blk_t blk_reg  [ROUNDS];
    blk_t blk_next [ROUNDS];
    logic cmd_reg  [ROUNDS];
    logic vld_reg  [ROUNDS];
    logic adv;
    blk_t in_blk;

    assign adv      = !vld_reg[ROUNDS-1] || m_tready;
    assign s_tready = adv && !busy_reg;
    assign in_blk.y = s_tdata[WORD_W-1:0];
    assign in_blk.x = s_tdata[2*WORD_W-1:WORD_W];

    genvar gi;
    generate
        for (gi = 0; gi < ROUNDS; gi++)
        begin : g_stage
            blk_t src;
            logic src_cmd;
            if (gi == 0)
            begin : g_first
                assign src     = in_blk;
                assign src_cmd = s_tuser;
            end
            else
            begin : g_rest
                assign src     = blk_reg[gi-1];
                assign src_cmd = cmd_reg[gi-1];
            end

            always_comb
            begin
                if (src_cmd == CMD_DEC)
                begin
                    blk_next[gi] = dec_round(src, rk_reg[ROUNDS-1-gi]);
                end
                else
                begin
                    blk_next[gi] = enc_round(src, rk_reg[gi]);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    blk_reg[gi] <= blk_next[gi];
                    cmd_reg[gi] <= src_cmd;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[gi] <= 1'b0;
                end
                else if (adv)
                begin
                    if (gi == 0)
                    begin
                        vld_reg[gi] <= s_tvalid && s_tready;
                    end
                    else
                    begin
                        vld_reg[gi] <= vld_reg[(gi > 0) ? gi-1 : 0];
                    end
                end
            end
        end
    endgenerate

    assign m_tvalid = vld_reg[ROUNDS-1];
    assign m_tdata  = {blk_reg[ROUNDS-1].x, blk_reg[ROUNDS-1].y};

endmodule

`default_nettype wire
